### rtl/core/fpa_pkg.sv
package fpa_pkg;

    // number format
    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    // divider widths: quotient covers |a| * 2^FRAC_BITS plus the rounding half
    localparam int QW        = WORD_W + FRAC_BITS;
    localparam int DW        = WORD_W;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_MUL     = 4'd2,
        FN_DIV     = 4'd3,
        FN_GT      = 4'd4,
        FN_LT      = 4'd5,
        FN_GE      = 4'd6,
        FN_LE      = 4'd7,
        FN_EQ      = 4'd8,
        FN_NE      = 4'd9,
        FN_MIN     = 4'd10,
        FN_MAX     = 4'd11,
        FN_TOINT   = 4'd12,
        FN_FROMINT = 4'd13,
        FN_INC     = 4'd14,
        FN_DEC     = 4'd15
    } func_t;

    // result and divide bookkeeping that rides along the pipe
    typedef struct packed {
        logic              is_div;
        logic              div_neg;
        logic              div_zero;
        logic [WORD_W-1:0] value;
        logic              flag;
        logic              err;
    } side_t;

    // divider working set: dividend bits shift out as quotient bits shift in
    typedef struct packed {
        logic [QW-1:0] dq;
        logic [DW-1:0] rem;
        logic [DW-1:0] den;
    } div_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              err;
    } sat_t;

    // apply sign to a rounded magnitude and saturate to the word range
    function automatic sat_t sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
        sat_t r;
        r.err   = 1'b0;
        r.value = mag[WORD_W-1:0];
        if (!neg) begin
            if (mag > {{(PROD_W-WORD_W){1'b0}}, WORD_MAX}) begin
                r.err   = 1'b1;
                r.value = WORD_MAX;
            end
        end else begin
            if (mag > {{(PROD_W-WORD_W){1'b0}}, WORD_MIN}) begin
                r.err   = 1'b1;
                r.value = WORD_MIN;
            end else begin
                r.value = -mag[WORD_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/fpa_front.sv
module fpa_front
    import fpa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [3:0]              func,
    input  logic [WORD_W-1:0]       operand_a,
    input  logic [WORD_W-1:0]       operand_b,
    output logic                    out_valid,
    output logic                    out_is_mul,
    output logic [PROD_W-1:0]       out_prod,
    output side_t                   out_side,
    output div_t                    out_div
);

    logic                valid_reg;
    logic                is_mul_reg, is_mul_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    side_t               side_reg, side_next;
    div_t                div_reg, div_next;

    logic signed [WORD_W-1:0] sa, sb;
    logic signed [PROD_W-1:0] wa, wb;
    logic [WORD_W:0]     sum, dif;
    logic [WORD_W-1:0]   abs_a, abs_b, tq;
    logic [FRAC_BITS:0]  top_a;
    logic                gt, lt, eq;

    assign sa = operand_a;
    assign sb = operand_b;

    // sign-extended operands so the product is formed at full width
    assign wa = PROD_W'(sa);
    assign wb = PROD_W'(sb);

    // decode and the operations that finish in this stage
    always_comb begin
        sum   = {operand_a[WORD_W-1], operand_a} + {operand_b[WORD_W-1], operand_b};
        dif   = {operand_a[WORD_W-1], operand_a} - {operand_b[WORD_W-1], operand_b};
        abs_a = operand_a[WORD_W-1] ? -operand_a : operand_a;
        abs_b = operand_b[WORD_W-1] ? -operand_b : operand_b;
        tq    = (abs_a + WORD_W'(2 ** (FRAC_BITS - 1))) >> FRAC_BITS;
        top_a = operand_a[WORD_W-1 -: FRAC_BITS+1];
        gt    = sa > sb;
        lt    = sa < sb;
        eq    = operand_a == operand_b;

        prod_next   = wa * wb;
        is_mul_next = 1'b0;

        side_next          = '0;
        side_next.div_neg  = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
        side_next.div_zero = operand_b == '0;

        div_next.rem = '0;
        div_next.den = abs_b;
        div_next.dq  = (QW'(abs_a) << FRAC_BITS) + QW'(abs_b >> 1);

        case (func_t'(func))
            FN_ADD: begin
                side_next.err   = sum[WORD_W] ^ sum[WORD_W-1];
                side_next.value = side_next.err ? (sum[WORD_W] ? WORD_MIN : WORD_MAX)
                                                : sum[WORD_W-1:0];
            end
            FN_SUB: begin
                side_next.err   = dif[WORD_W] ^ dif[WORD_W-1];
                side_next.value = side_next.err ? (dif[WORD_W] ? WORD_MIN : WORD_MAX)
                                                : dif[WORD_W-1:0];
            end
            FN_MUL:  is_mul_next = 1'b1;
            FN_DIV:  side_next.is_div = 1'b1;
            FN_GT:   side_next.flag = gt;
            FN_LT:   side_next.flag = lt;
            FN_GE:   side_next.flag = !lt;
            FN_LE:   side_next.flag = !gt;
            FN_EQ:   side_next.flag = eq;
            FN_NE:   side_next.flag = !eq;
            FN_MIN:  side_next.value = gt ? operand_b : operand_a;
            FN_MAX:  side_next.value = lt ? operand_b : operand_a;
            FN_TOINT: side_next.value = operand_a[WORD_W-1] ? -tq : tq;
            FN_FROMINT: begin
                side_next.err   = !((&top_a) || !(|top_a));
                side_next.value = side_next.err ? (operand_a[WORD_W-1] ? WORD_MIN : WORD_MAX)
                                                : (operand_a << FRAC_BITS);
            end
            FN_INC: begin
                side_next.err   = operand_a == WORD_MAX;
                side_next.value = side_next.err ? WORD_MAX : operand_a + WORD_W'(1);
            end
            FN_DEC: begin
                side_next.err   = operand_a == WORD_MIN;
                side_next.value = side_next.err ? WORD_MIN : operand_a - WORD_W'(1);
            end
            default: side_next.value = '0;
        endcase
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            is_mul_reg <= is_mul_next;
            prod_reg   <= prod_next;
            side_reg   <= side_next;
            div_reg    <= div_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_is_mul = is_mul_reg;
    assign out_prod   = prod_reg;
    assign out_side   = side_reg;
    assign out_div    = div_reg;

endmodule

### rtl/core/fpa_mul_round.sv
module fpa_mul_round
    import fpa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic                in_is_mul,
    input  logic [PROD_W-1:0]   in_prod,
    input  side_t               in_side,
    input  div_t                in_div,
    output logic                out_valid,
    output side_t               out_side,
    output div_t                out_div
);

    logic                valid_a_reg, valid_b_reg;
    logic                is_mul_a_reg;
    logic                neg_a_reg;
    logic [PROD_W-1:0]   mag_a_reg;
    side_t               side_a_reg, side_b_reg, side_b_next;
    div_t                div_a_reg, div_b_reg;
    logic [PROD_W-1:0]   rnd;
    sat_t                sat;

    // round to nearest, ties away from zero, then saturate
    always_comb begin
        rnd         = (mag_a_reg + PROD_W'(2 ** (FRAC_BITS - 1))) >> FRAC_BITS;
        sat         = sat_mag(neg_a_reg, rnd);
        side_b_next = side_a_reg;
        if (is_mul_a_reg) begin
            side_b_next.value = sat.value;
            side_b_next.err   = sat.err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (adv) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
        // product magnitude stage, then rounding stage
        if (adv) begin
            is_mul_a_reg <= in_is_mul;
            neg_a_reg    <= in_prod[PROD_W-1];
            mag_a_reg    <= in_prod[PROD_W-1] ? -in_prod : in_prod;
            side_a_reg   <= in_side;
            div_a_reg    <= in_div;
            side_b_reg   <= side_b_next;
            div_b_reg    <= div_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_side  = side_b_reg;
    assign out_div   = div_b_reg;

endmodule

### rtl/core/fpa_div_stage.sv
module fpa_div_stage
    import fpa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    adv,
    input  logic    in_valid,
    input  side_t   in_side,
    input  div_t    in_div,
    output logic    out_valid,
    output side_t   out_side,
    output div_t    out_div
);

    logic          valid_reg;
    side_t         side_reg;
    div_t          div_reg, div_next;
    logic [DW:0]   shifted;
    logic          ge;

    // one restoring step: bring down a dividend bit, subtract if it fits
    always_comb begin
        shifted      = {in_div.rem, in_div.dq[QW-1]};
        ge           = shifted >= {1'b0, in_div.den};
        div_next.den = in_div.den;
        div_next.rem = ge ? DW'(shifted - {1'b0, in_div.den}) : shifted[DW-1:0];
        div_next.dq  = {in_div.dq[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

endmodule

### rtl/core/fixed_point_alu_unit.sv
// Q24.8 fixed-point ALU: add, sub, mul, div (round to nearest, ties away from
// zero, saturating with error), six compares as a flag, min, max, toint,
// fromint, inc and dec. One transaction is accepted every cycle while the
// result side keeps up. Each result passes the front stage, the product
// magnitude and rounding stages, the divider stages and the output register;
// the divider resolves one quotient bit per pipeline stage. Every operation
// travels the same pipe, so results leave in input order. A stalled output
// freezes the whole pipe, and s_tready then follows m_tready.
module fixed_point_alu_unit
    import fpa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [7:0]          s_tuser,   // func [3:0], zero [7:4]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // value [31:0]
    output logic [7:0]          m_tuser    // flag [0], error [1], zero [7:2]
);

    logic                adv;
    logic                f_valid, f_is_mul;
    logic [PROD_W-1:0]   f_prod;
    side_t               f_side;
    div_t                f_div;

    logic                v_chain [QW+1];
    side_t               s_chain [QW+1];
    div_t                d_chain [QW+1];

    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_value_reg, m_value_next;
    logic                m_flag_reg, m_flag_next;
    logic                m_err_reg, m_err_next;
    side_t               tail;
    sat_t                dsat;

    // whole pipe moves unless a finished result is waiting
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    fpa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .func       (s_tuser[3:0]),
        .operand_a  (s_tdata[31:0]),
        .operand_b  (s_tdata[63:32]),
        .out_valid  (f_valid),
        .out_is_mul (f_is_mul),
        .out_prod   (f_prod),
        .out_side   (f_side),
        .out_div    (f_div)
    );

    fpa_mul_round u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (f_valid),
        .in_is_mul  (f_is_mul),
        .in_prod    (f_prod),
        .in_side    (f_side),
        .in_div     (f_div),
        .out_valid  (v_chain[0]),
        .out_side   (s_chain[0]),
        .out_div    (d_chain[0])
    );

    // divider, one quotient bit per stage
    for (genvar i = 0; i < QW; i++) begin : g_div
        fpa_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v_chain[i]),
            .in_side   (s_chain[i]),
            .in_div    (d_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_side  (s_chain[i+1]),
            .out_div   (d_chain[i+1])
        );
    end

    // finish divides and pick the result
    always_comb begin
        tail         = s_chain[QW];
        dsat         = sat_mag(tail.div_neg, PROD_W'(d_chain[QW].dq));
        m_value_next = tail.value;
        m_flag_next  = tail.flag;
        m_err_next   = tail.err;
        if (tail.is_div) begin
            m_flag_next = 1'b0;
            if (tail.div_zero) begin
                m_value_next = '0;
                m_err_next   = 1'b1;
            end else begin
                m_value_next = dsat.value;
                m_err_next   = dsat.err;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_chain[QW];
        end
        if (adv) begin
            m_value_reg <= m_value_next;
            m_flag_reg  <= m_flag_next;
            m_err_reg   <= m_err_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {6'b0, m_err_reg, m_flag_reg};

    // a compare never errors
    a_flag_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_flag_reg && m_err_reg))
        else $error("flag and error both set");

    // a compare result carries a zero value
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_flag_reg) |-> (m_value_reg == '0))
        else $error("compare result with nonzero value");

    // an error always comes with a bound or the divide-by-zero zero
    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_err_reg) |->
            (m_value_reg == WORD_MAX || m_value_reg == WORD_MIN || m_value_reg == '0))
        else $error("error with non-saturated value");

    // a held result freezes the pipe
    a_hold_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> $stable(v_chain[QW]) && m_valid_reg)
        else $error("pipe moved under a stalled result");

endmodule
